// ===== src/bgc_pkg.sv =====
// Package for the button gesture classifier: types, codes and reset constants.
`timescale 1ns / 1ps

package bgc_pkg;

    // Default width of stored timestamps and time differences
    localparam int TIME_BITS_DEFAULT = 32;

    // Configuration register geometry
    localparam int CFG_BITS   = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register indexes
    localparam logic REG_LONG_PRESS   = 1'b0;
    localparam logic REG_DOUBLE_CLICK = 1'b1;

    // Register reset values
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET   = 16'd2000;
    localparam logic [CFG_BITS-1:0] DOUBLE_CLICK_RESET = 16'd300;

    // Gesture state codes
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_PRESSED  = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_SECOND   = 2'd3;

    // Configuration values handed to the gesture logic
    typedef struct packed {
        logic [CFG_BITS-1:0] long_press_ms;
        logic [CFG_BITS-1:0] double_click_ms;
    } bgc_cfg_t;

    // One result: the three gesture pulses
    typedef struct packed {
        logic single_click;
        logic long_press;
        logic double_click;
    } bgc_result_t;

endpackage

// ===== src/bgc_cfg.sv =====
// APB register file holding the long-press time and the double-click window.
`timescale 1ns / 1ps

module bgc_cfg
    import bgc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output bgc_cfg_t              cfg
);

    logic [CFG_BITS-1:0] long_press_reg;
    logic [CFG_BITS-1:0] double_click_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write the addressed register; upper data bits drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg   <= LONG_PRESS_RESET;
            double_click_reg <= DOUBLE_CLICK_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_LONG_PRESS:   long_press_reg   <= pwdata[CFG_BITS-1:0];
                REG_DOUBLE_CLICK: double_click_reg <= pwdata[CFG_BITS-1:0];
                default:          long_press_reg   <= long_press_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (paddr[2])
            REG_LONG_PRESS:   prdata = APB_DATA_W'(long_press_reg);
            REG_DOUBLE_CLICK: prdata = APB_DATA_W'(double_click_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.long_press_ms   = long_press_reg;
    assign cfg.double_click_ms = double_click_reg;

endmodule

// ===== src/bgc_fsm.sv =====
// Gesture state machine: state registers and the single-pass next-state logic.
`timescale 1ns / 1ps

module bgc_fsm
    import bgc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 upd,
    input  logic                 pressed,
    input  logic [TIME_BITS-1:0] now,
    input  bgc_cfg_t             cfg,
    output bgc_result_t          res
);

    logic [1:0]           state_reg, state_next;
    logic [TIME_BITS-1:0] press_start_reg, press_start_next;
    logic [TIME_BITS-1:0] first_release_reg, first_release_next;
    logic                 long_done_reg, long_done_next;
    logic                 click_done_reg, click_done_next;

    logic [TIME_BITS-1:0] rel_diff;
    logic [TIME_BITS-1:0] hold_diff;
    logic [TIME_BITS-1:0] dc_win;
    logic [TIME_BITS-1:0] lp_time;

    assign dc_win   = TIME_BITS'(cfg.double_click_ms);
    assign lp_time  = TIME_BITS'(cfg.long_press_ms);
    assign rel_diff = now - first_release_reg;

    // Follow the button, then check the hold on the updated state
    always_comb begin
        state_next         = state_reg;
        press_start_next   = press_start_reg;
        first_release_next = first_release_reg;
        long_done_next     = long_done_reg;
        click_done_next    = click_done_reg;
        res                = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (pressed) begin
                    state_next       = ST_PRESSED;
                    press_start_next = now;
                    long_done_next   = 1'b0;
                    click_done_next  = 1'b0;
                end
            end
            ST_PRESSED: begin
                if (!pressed) begin
                    state_next         = ST_RELEASED;
                    first_release_next = now;
                end
            end
            ST_RELEASED: begin
                // window expiry and a new press may land on one sample
                if (rel_diff > dc_win) begin
                    if (!click_done_reg) begin
                        res.single_click = 1'b1;
                        click_done_next  = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                if (pressed) begin
                    state_next       = ST_SECOND;
                    press_start_next = now;
                end
            end
            ST_SECOND: begin
                if (!pressed) begin
                    res.double_click = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        hold_diff = now - press_start_next;
        if (state_next == ST_PRESSED && !long_done_next && hold_diff >= lp_time) begin
            res.long_press  = 1'b1;
            long_done_next  = 1'b1;
            click_done_next = 1'b1;
        end
    end

    // Commit the state when a request leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            press_start_reg   <= '0;
            first_release_reg <= '0;
            long_done_reg     <= 1'b0;
            click_done_reg    <= 1'b0;
        end else if (upd) begin
            state_reg         <= state_next;
            press_start_reg   <= press_start_next;
            first_release_reg <= first_release_next;
            long_done_reg     <= long_done_next;
            click_done_reg    <= click_done_next;
        end
    end

`ifndef SYNTH
    // a double click only comes out of the second press
    a_dbl_from_second: assert property (@(posedge aclk) disable iff (!aresetn)
        upd && res.double_click |-> state_reg == ST_SECOND)
        else $error("double click outside second press");

    // a long press claims the click and is not repeated
    a_long_sets_done: assert property (@(posedge aclk) disable iff (!aresetn)
        upd && res.long_press |=> long_done_reg && click_done_reg)
        else $error("long press did not set done flags");

    // a single click only fires on leaving the released state
    a_single_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        upd && res.single_click |=> state_reg == ST_IDLE || state_reg == ST_SECOND)
        else $error("single click without leaving released state");
`endif

endmodule

// ===== src/button_gesture_classifier.sv =====
// Top level of the button gesture classifier: channels, pipeline registers, config.
`timescale 1ns / 1ps

// Button gesture classifier.
// Input channel (s_valid/s_ready): one sample per request, the button level
// s_pressed and the millisecond timestamp s_now_ms. Result channel
// (m_valid/m_ready): exactly one result per sample, with one-sample pulses
// m_single_click, m_long_press and m_double_click.
// A sample is captured in the input register, passes through the gesture
// logic and lands in the result register, which drives m_valid.
// Throughput is one sample per cycle while the receiver keeps m_ready high,
// as the gesture state registers update on every advance.
// When the receiver stalls, the result register holds, the input register
// keeps the next sample, and s_ready drops once both are full; no state is
// updated until the held sample can move on.
// Reset (aresetn low, synchronous) empties both registers, returns the
// machine to idle with cleared times and flags, and loads the defaults
// long_press_ms = 2000 and double_click_ms = 300.
// Configuration is written over the APB port (register 0 at address 0, register
// 1 at address 4); the user must write it only while the block is idle (not enforced).

module button_gesture_classifier
    import bgc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_pressed,
    input  logic [31:0]           s_now_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_single_click,
    output logic                  m_long_press,
    output logic                  m_double_click,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    bgc_cfg_t    cfg;
    bgc_result_t res;
    bgc_result_t out_res_reg;

    logic                 in_vld_reg;
    logic                 in_pressed_reg;
    logic [TIME_BITS-1:0] in_now_reg;
    logic                 out_vld_reg;
    logic                 adv;

    // Advance when the input register holds a sample and the result register is empty or being drained
    assign adv     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;

    bgc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bgc_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (adv),
        .pressed (in_pressed_reg),
        .now     (in_now_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Input register: take a request whenever there is room
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_pressed_reg <= s_pressed;
            in_now_reg     <= TIME_BITS'(s_now_ms);
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg <= res;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_single_click = out_res_reg.single_click;
    assign m_long_press   = out_res_reg.long_press;
    assign m_double_click = out_res_reg.double_click;

`ifndef SYNTH
    // gestures exclude each other on one sample
    a_onehot_res: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_single_click, m_long_press, m_double_click}))
        else $error("more than one gesture on one result");
`endif

endmodule

// ===== bench/button_gesture_classifier_tb.sv =====
// Self-checking testbench for the button gesture classifier: gesture stimulus and pulse checks.
`timescale 1ns / 1ps

module button_gesture_classifier_tb;
    import bgc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS = 320;

    localparam logic [APB_ADDR_W-1:0] ADDR_LONG_PRESS   = APB_ADDR_W'(4 * REG_LONG_PRESS);
    localparam logic [APB_ADDR_W-1:0] ADDR_DOUBLE_CLICK = APB_ADDR_W'(4 * REG_DOUBLE_CLICK);

    typedef struct packed {
        logic        pressed;
        logic [31:0] now_ms;
    } button_sample_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_pressed = 1'b0;
    logic [31:0]           s_now_ms = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_single_click;
    logic                  m_long_press;
    logic                  m_double_click;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    button_gesture_classifier u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pressed      (s_pressed),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_single_click (m_single_click),
        .m_long_press   (m_long_press),
        .m_double_click (m_double_click),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Pending samples, expected pulses and bookkeeping
    button_sample_t button_samples_q[$];
    bgc_result_t    expected_gestures_q[$];
    int             sent_count = 0;
    int             rx_count = 0;
    int             error_count = 0;
    int             mismatch_count = 0;
    bit             idle_on = 1'b1;
    logic [31:0]    t_cur = 32'hFFFF_FF00;

    // Shadow configuration
    logic [CFG_BITS-1:0] long_press_cfg = LONG_PRESS_RESET;
    logic [CFG_BITS-1:0] double_click_cfg = DOUBLE_CLICK_RESET;

    // Shadow gesture state
    logic [1:0]  gesture_st = ST_IDLE;
    logic [31:0] press_start_ms = '0;
    logic [31:0] first_release_ms = '0;
    logic        long_claimed = 1'b0;
    logic        click_claimed = 1'b0;

    // Clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Advance the gesture machine by one sample and return its pulses
    function automatic bgc_result_t classify_sample(input logic down, input logic [31:0] now);
        bgc_result_t pulses;
        logic [31:0] since_release;
        logic [31:0] held_for;
        pulses = '0;
        since_release = now - first_release_ms;
        case (gesture_st)
            ST_IDLE: begin
                if (down) begin
                    gesture_st = ST_PRESSED;
                    press_start_ms = now;
                    long_claimed = 1'b0;
                    click_claimed = 1'b0;
                end
            end
            ST_PRESSED: begin
                if (!down) begin
                    first_release_ms = now;
                    gesture_st = ST_RELEASED;
                end
            end
            ST_RELEASED: begin
                // window expiry and a new press are evaluated independently
                if (since_release > {16'b0, double_click_cfg}) begin
                    if (!click_claimed) begin
                        pulses.single_click = 1'b1;
                        click_claimed = 1'b1;
                    end
                    gesture_st = ST_IDLE;
                end
                if (down) begin
                    gesture_st = ST_SECOND;
                    press_start_ms = now;
                end
            end
            default: begin
                if (!down) begin
                    pulses.double_click = 1'b1;
                    gesture_st = ST_IDLE;
                end
            end
        endcase
        // long press check runs on the updated state
        held_for = now - press_start_ms;
        if (gesture_st == ST_PRESSED && !long_claimed && held_for >= {16'b0, long_press_cfg}) begin
            pulses.long_press = 1'b1;
            long_claimed = 1'b1;
            click_claimed = 1'b1;
        end
        return pulses;
    endfunction

    // Stimulus helpers
    task automatic push_sample(input logic lvl, input logic [31:0] ts);
        button_sample_t smp;
        smp.pressed = lvl;
        smp.now_ms = ts;
        button_samples_q.push_back(smp);
        sent_count++;
    endtask

    task automatic step_sample(input logic lvl, input logic [31:0] dt);
        t_cur = t_cur + dt;
        push_sample(lvl, t_cur);
    endtask

    function automatic logic [31:0] jitter_around(input logic [CFG_BITS-1:0] thr);
        return {16'b0, thr} + 32'($urandom_range(0, 2)) - 32'd1;
    endfunction

    function automatic logic [31:0] short_gap();
        return 32'($urandom_range(0, 30));
    endfunction

    // Emit one well-formed gesture with random timing around the thresholds
    task automatic gen_gesture(output int n);
        int kind;
        kind = $urandom_range(0, 4);
        n = 0;
        step_sample(1'b1, short_gap() + 32'd1);
        n++;
        case (kind)
            0: begin
                step_sample(1'b0, short_gap());
                step_sample(1'b0, jitter_around(double_click_cfg));
                step_sample(1'b0, 32'($urandom_range(0, 3)));
                n += 3;
            end
            1: begin
                step_sample(1'b1, jitter_around(long_press_cfg));
                step_sample(1'b1, 32'($urandom_range(0, 3)));
                step_sample(1'b0, short_gap());
                step_sample(1'b0, jitter_around(double_click_cfg) + 32'd1);
                n += 4;
            end
            2: begin
                step_sample(1'b0, short_gap());
                step_sample(1'b1, jitter_around(double_click_cfg));
                step_sample(1'b0, short_gap());
                n += 3;
            end
            3: begin
                step_sample(1'b0, short_gap());
                step_sample(1'b1, short_gap());
                step_sample(1'b1, jitter_around(long_press_cfg) + 32'd1);
                step_sample(1'b0, short_gap());
                n += 4;
            end
            default: begin
                // next press lands on the last sample of the window or just after it runs out
                step_sample(1'b0, short_gap());
                step_sample(1'b1, jitter_around(double_click_cfg) + 32'd1);
                step_sample(1'b0, short_gap());
                n += 3;
            end
        endcase
    endtask

    // Fill one phase with gestures, random walks and raw noise
    task automatic gen_random(input int total);
        int made;
        int n;
        int pick;
        int k;
        logic lvl;
        logic [31:0] dt;
        made = 0;
        lvl = 1'b0;
        while (made < total) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                gen_gesture(n);
                made += n;
                lvl = 1'b0;
            end else if (pick < 90) begin
                for (k = 0; k < 5; k++) begin
                    if ($urandom_range(0, 99) < 35) lvl = ~lvl;
                    case ($urandom_range(0, 7))
                        0: dt = '0;
                        1: dt = 32'($urandom_range(1, 20));
                        2: dt = {16'b0, long_press_cfg} - 32'd1;
                        3: dt = {16'b0, long_press_cfg};
                        4: dt = {16'b0, long_press_cfg} + 32'd1;
                        5: dt = {16'b0, double_click_cfg};
                        6: dt = {16'b0, double_click_cfg} + 32'd1;
                        default: dt = 32'($urandom_range(0, 140000));
                    endcase
                    step_sample(lvl, dt);
                end
                made += 5;
            end else begin
                t_cur = $urandom();
                lvl = 1'($urandom_range(0, 1));
                push_sample(lvl, t_cur);
                made++;
            end
        end
    endtask

    // APB access helpers
    task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic cfg_read_check(input logic [APB_ADDR_W-1:0] addr, input logic [15:0] want);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[15:0] !== want) begin
            error_count++;
            $display("register readback at %0d: expected %0d, got %0d", addr, want, prdata[15:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write both registers, mirror them, and read them back
    task automatic cfg_apply(input logic [31:0] lp_word, input logic [31:0] dc_word);
        cfg_write(ADDR_LONG_PRESS, lp_word);
        cfg_write(ADDR_DOUBLE_CLICK, dc_word);
        long_press_cfg = lp_word[CFG_BITS-1:0];
        double_click_cfg = dc_word[CFG_BITS-1:0];
        cfg_read_check(ADDR_LONG_PRESS, long_press_cfg);
        cfg_read_check(ADDR_DOUBLE_CLICK, double_click_cfg);
    endtask

    // Hold until every request has come back, then let the pipeline settle
    task automatic drain();
        @(posedge aclk);
        while (rx_count < sent_count) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Driver: feed samples from the pending queue, with random gaps while idling is on
    int drv_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_gestures_q.push_back(classify_sample(s_pressed, s_now_ms));
            end
            if (!s_valid || s_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_valid <= 1'b0;
                end else if (button_samples_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_pressed <= button_samples_q[0].pressed;
                    s_now_ms <= button_samples_q[0].now_ms;
                    void'(button_samples_q.pop_front());
                    if (idle_on && $urandom_range(0, 3) == 0) drv_gap = $urandom_range(1, 5);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result and drive back-pressure
    int  rx_stall = 0;
    int  long_hold = 0;
    bit  long_hold_done = 1'b0;
    always @(posedge aclk) begin
        bgc_result_t got;
        bgc_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.single_click = m_single_click;
                got.long_press = m_long_press;
                got.double_click = m_double_click;
                rx_count++;
                if (expected_gestures_q.size() == 0) begin
                    error_count++;
                    $display("unexpected result: single=%b long=%b double=%b",
                             got.single_click, got.long_press, got.double_click);
                end else begin
                    want = expected_gestures_q.pop_front();
                    if (got !== want) begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"result %0d: expected single=%b long=%b double=%b, ",
                                      "got single=%b long=%b double=%b"},
                                     rx_count, want.single_click, want.long_press,
                                     want.double_click, got.single_click, got.long_press,
                                     got.double_click);
                        end
                    end
                end
            end
            // long hold-off once, so the input side fills and stalls
            if (long_hold > 0) begin
                long_hold--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && rx_count >= 200) begin
                long_hold_done = 1'b1;
                long_hold = LONG_HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                rx_stall = $urandom_range(1, 5) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults, with junk in the upper register bits
        cfg_apply(32'hFFFF_07D0, 32'h5A5A_012C);

        // directed gestures, starting just below the timestamp wrap
        push_sample(1'b0, t_cur);
        push_sample(1'b1, t_cur);
        push_sample(1'b0, t_cur + 32'd10);
        push_sample(1'b0, t_cur + 32'd310);
        push_sample(1'b0, t_cur + 32'd311);
        push_sample(1'b1, t_cur + 32'd400);
        push_sample(1'b0, t_cur + 32'd405);
        push_sample(1'b1, t_cur + 32'd706);
        push_sample(1'b1, t_cur + 32'd5000);
        push_sample(1'b0, t_cur + 32'd5001);
        push_sample(1'b1, t_cur + 32'd6000);
        push_sample(1'b1, t_cur + 32'd7999);
        push_sample(1'b1, t_cur + 32'd8000);
        push_sample(1'b1, t_cur + 32'd9000);
        push_sample(1'b0, t_cur + 32'd9001);
        push_sample(1'b0, t_cur + 32'd9400);
        push_sample(1'b1, t_cur + 32'd10000);
        push_sample(1'b1, t_cur + 32'd12000);
        push_sample(1'b0, t_cur + 32'd12001);
        push_sample(1'b1, t_cur + 32'd12100);
        push_sample(1'b0, t_cur + 32'd12101);
        push_sample(1'b1, 32'hFFFF_FFFF);
        push_sample(1'b0, 32'h0000_0000);
        drain();

        // zero thresholds: immediate long press and a window that expires on any later timestamp
        cfg_apply(32'hABCD_0000, 32'h8000_0000);
        push_sample(1'b0, 32'd5);
        push_sample(1'b1, 32'd5);
        push_sample(1'b0, 32'd5);
        push_sample(1'b0, 32'd5);
        push_sample(1'b0, 32'd6);
        push_sample(1'b1, 32'd6);
        t_cur = 32'd6;
        gen_random(PHASE_ITEMS);
        drain();

        cfg_apply(32'h0000_0001, 32'hFFFF_0001);
        gen_random(PHASE_ITEMS);
        drain();

        cfg_apply(32'h0000_FFFF, 32'h0000_FFFF);
        gen_random(PHASE_ITEMS);
        drain();

        cfg_apply($urandom(), $urandom());
        gen_random(PHASE_ITEMS);
        drain();

        cfg_apply(32'd2000, 32'd300);
        gen_random(PHASE_ITEMS);
        drain();

        // last phase runs without idling on either side
        cfg_apply(32'($urandom_range(1, 200)), 32'($urandom_range(1, 100)));
        idle_on = 1'b0;
        gen_random(PHASE_ITEMS);
        drain();

        if (error_count == 0 && expected_gestures_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bgc_pkg.sv
src/bgc_cfg.sv
src/bgc_fsm.sv
src/button_gesture_classifier.sv
bench/button_gesture_classifier_tb.sv
